>>> hw/rtl/sfr_pkg.sv
package sfr_pkg;

    localparam int MAX_CHANNELS = 14;

    localparam logic [1:0] REG_HEADER_FIRST   = 2'd0;
    localparam logic [1:0] REG_HEADER_SECOND  = 2'd1;
    localparam logic [1:0] REG_CHECKSUM_START = 2'd2;

    localparam logic [7:0]  RST_HEADER_FIRST   = 8'h20;
    localparam logic [7:0]  RST_HEADER_SECOND  = 8'h40;
    localparam logic [15:0] RST_CHECKSUM_START = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [15:0] checksum_start;
    } t_cfg;

    typedef struct packed {
        logic start_frame;
        logic store_byte;
        logic emit_start;
        logic rd_lo;
        logic rd_hi;
        logic cap_hi;
        logic next_chan;
    } t_cmd;

    typedef struct packed {
        logic hdr1_match;
        logic hdr2_match;
        logic frame_end;
        logic ck_ok;
        logic last_chan;
    } t_sts;

endpackage

>>> hw/rtl/sfr_in_if.sv
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/sfr_out_if.sv
interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] channel_value;
    logic [3:0]  channel_index;
    logic        last_channel;

    modport source (output valid, output channel_value, output channel_index,
                    output last_channel, input ready);
    modport sink   (input valid, input channel_value, input channel_index,
                    input last_channel, output ready);
endinterface

>>> hw/rtl/sfr_ram.sv
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/sfr_regs.sv
module sfr_regs import sfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first   <= RST_HEADER_FIRST;
            r_cfg.header_second  <= RST_HEADER_SECOND;
            r_cfg.checksum_start <= RST_CHECKSUM_START;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_HEADER_FIRST:   r_cfg.header_first   <= pwdata[7:0];
                REG_HEADER_SECOND:  r_cfg.header_second  <= pwdata[7:0];
                REG_CHECKSUM_START: r_cfg.checksum_start <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HEADER_FIRST:   prdata = {24'd0, r_cfg.header_first};
            REG_HEADER_SECOND:  prdata = {24'd0, r_cfg.header_second};
            REG_CHECKSUM_START: prdata = {16'd0, r_cfg.checksum_start};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/sfr_datapath.sv
module sfr_datapath import sfr_pkg::*; #(
    parameter int FRAME_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_rx_byte,
    output t_sts        o_sts,
    output logic [15:0] o_channel_value,
    output logic [3:0]  o_channel_index,
    output logic        o_last_channel
);

    localparam int AW  = $clog2(FRAME_BYTES);
    localparam int RAW = (FRAME_BYTES - 4) / 2;
    localparam int NCH = (RAW < MAX_CHANNELS) ? RAW : MAX_CHANNELS;

    logic [AW-1:0] r_cnt;
    logic [15:0]   r_sum;
    logic [7:0]    r_ck_lo;
    logic [3:0]    r_chan;
    logic [7:0]    r_lo;
    logic [15:0]   r_value;
    logic [3:0]    r_index;
    logic          r_last;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_raddr_full;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    assign w_we         = i_cmd.start_frame || i_cmd.store_byte;
    assign w_waddr      = i_cmd.start_frame ? '0 : r_cnt;
    assign w_raddr_full = {27'd0, r_chan, 1'b0} + 32'd2 + {31'd0, i_cmd.rd_hi};
    assign w_raddr      = w_raddr_full[AW-1:0];

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_lo || i_cmd.rd_hi),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_chan <= '0;
        end else begin
            if (i_cmd.start_frame) begin
                r_cnt <= AW'(1);
            end else if (i_cmd.store_byte) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (i_cmd.emit_start) begin
                r_chan <= '0;
            end else if (i_cmd.next_chan) begin
                r_chan <= r_chan + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_frame) begin
            r_sum <= i_cfg.checksum_start - {8'd0, i_rx_byte};
        end else if (i_cmd.store_byte && (r_cnt <= AW'(FRAME_BYTES - 3))) begin
            r_sum <= r_sum - {8'd0, i_rx_byte};
        end
        if (i_cmd.store_byte && (r_cnt == AW'(FRAME_BYTES - 2))) begin
            r_ck_lo <= i_rx_byte;
        end
        if (i_cmd.rd_hi) begin
            r_lo <= w_rdata;
        end
        if (i_cmd.cap_hi) begin
            r_value <= {w_rdata, r_lo};
            r_index <= r_chan;
            r_last  <= (r_chan == 4'(NCH - 1));
        end
    end

    assign o_sts.hdr1_match = (i_rx_byte == i_cfg.header_first);
    assign o_sts.hdr2_match = (i_rx_byte == i_cfg.header_second);
    assign o_sts.frame_end  = (r_cnt == AW'(FRAME_BYTES - 1));
    assign o_sts.ck_ok      = ({i_rx_byte, r_ck_lo} == r_sum);
    assign o_sts.last_chan  = (r_chan == 4'(NCH - 1));

    assign o_channel_value = r_value;
    assign o_channel_index = r_index;
    assign o_last_channel  = r_last;

endmodule

>>> hw/rtl/sfr_ctrl.sv
module sfr_ctrl import sfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_WAIT,
        S_HALF,
        S_BODY,
        S_RD_LO,
        S_RD_HI,
        S_CAP,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_ready  = (r_state == S_WAIT) || (r_state == S_HALF) || (r_state == S_BODY);
    assign o_out_valid = (r_state == S_OUT);
    assign w_acc       = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_WAIT: begin
                if (w_acc && i_sts.hdr1_match) begin
                    o_cmd.start_frame = 1'b1;
                    n_state = S_HALF;
                end
            end
            S_HALF: begin
                if (w_acc) begin
                    if (i_sts.hdr2_match) begin
                        o_cmd.store_byte = 1'b1;
                        n_state = S_BODY;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_BODY: begin
                if (w_acc) begin
                    o_cmd.store_byte = 1'b1;
                    if (i_sts.frame_end) begin
                        if (i_sts.ck_ok) begin
                            o_cmd.emit_start = 1'b1;
                            n_state = S_RD_LO;
                        end else begin
                            n_state = S_WAIT;
                        end
                    end
                end
            end
            S_RD_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap_hi = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_sts.last_chan) begin
                        n_state = S_WAIT;
                    end else begin
                        o_cmd.next_chan = 1'b1;
                        n_state = S_RD_LO;
                    end
                end
            end
            default: n_state = S_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output active together");

    a_last_resumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_sts.last_chan) |=> o_in_ready)
        else $error("hunt not resumed after last channel");

    a_start_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start_frame || o_cmd.store_byte) |-> w_acc)
        else $error("byte stored without a transaction");

    a_bad_ck_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BODY && w_acc && i_sts.frame_end && !i_sts.ck_ok)
        |=> (r_state == S_WAIT))
        else $error("bad checksum frame not dropped");
`endif

endmodule

>>> hw/rtl/servo_frame_receiver.sv
// Servo frame receiver: decodes 32-byte serial-bus servo frames.
// i_rx (valid/ready): one received byte per transaction. Bytes are taken in
//   one cycle each while the block is hunting or collecting a frame.
// o_chan (valid/ready): on a frame whose checksum matches, 14 transactions
//   carry the channel words, index 0 first, last_channel set on the final one.
//   A frame with a bad checksum gives no output and hunting restarts.
// APB port: header_first at 0x0, header_second at 0x4, checksum_start at 0x8.
//   Write only while idle; new values apply from the next frame.
// Output: each word is read from the frame RAM as two bytes, low then high,
//   through the states S_RD_LO, S_RD_HI and S_CAP before it is shown in
//   S_OUT. No byte is accepted until the last channel word has been taken.
// If the receiver stalls, the current word is held and the sequencer waits.
// Reset: headers 0x20/0x40, checksum start 0xFFFF, block hunts for a header.
module servo_frame_receiver import sfr_pkg::*; #(
    parameter int FRAME_BYTES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sfr_in_if.sink           i_rx,
    sfr_out_if.source        o_chan,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    sfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .i_out_ready (o_chan.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_rx.ready),
        .o_out_valid (o_chan.valid),
        .o_cmd       (w_cmd)
    );

    sfr_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .i_rx_byte       (i_rx.rx_byte),
        .o_sts           (w_sts),
        .o_channel_value (o_chan.channel_value),
        .o_channel_index (o_chan.channel_index),
        .o_last_channel  (o_chan.last_channel)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import sfr_pkg::*;

    localparam int FRAME_LEN   = 32;
    localparam int RAW_WORDS   = (FRAME_LEN - 4) / 2;
    localparam int NUM_WORDS   = (RAW_WORDS < MAX_CHANNELS) ? RAW_WORDS : MAX_CHANNELS;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 100;
    localparam int LIMIT       = 300000;

    typedef enum logic [1:0] {
        SEEK_FIRST  = 2'd0,
        SEEK_SECOND = 2'd1,
        IN_FRAME    = 2'd2
    } hunt_t;

    typedef enum logic [1:0] {
        FRAME_OK,
        FRAME_BAD_SUM,
        SECOND_HDR_MISS,
        FRAME_RANDOM
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] fill;
        int          words;
    } dir_row_t;

    typedef struct {
        logic [15:0] value;
        logic [3:0]  index;
        logic        last;
    } chan_word_t;

    typedef logic [15:0] word_set_t [NUM_WORDS];

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sfr_in_if  rx_if ();
    sfr_out_if chan_if ();

    servo_frame_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_chan  (chan_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow configuration and frame decoder state
    logic [7:0]  cfg_hdr1;
    logic [7:0]  cfg_hdr2;
    logic [15:0] cfg_ck;
    hunt_t       hunt;
    int unsigned got;
    logic [15:0] acc;
    logic [7:0]  fbuf [FRAME_LEN];

    // directed rows supply their own expected words
    bit          typed_on;
    int          typed_words;
    logic [15:0] typed_value;

    chan_word_t pending_words [$];
    chan_word_t seen_word;
    int         mismatches;
    int         idle_pct;
    int         stall_pct;
    int         hold_req;
    int         hold_seen;
    int         hold_left;
    int         cycles;

    dir_row_t dir_rows [3] = '{
        '{FRAME_OK,        16'hFFFF, 14},
        '{FRAME_BAD_SUM,   16'h1234, 0},
        '{SECOND_HDR_MISS, 16'h0000, 0}
    };

    always #1 i_clk = ~i_clk;

    function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        if (mismatches < 10) begin
            $display("%0t: %s: expected %h, got %h", $realtime, what, exp_v, act_v);
        end
        mismatches++;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic [15:0] given;
        case (hunt)
            SEEK_SECOND: begin
                if (b == cfg_hdr2) begin
                    if (got < FRAME_LEN) fbuf[got] = b;
                    got++;
                    acc  = acc - {8'd0, b};
                    hunt = IN_FRAME;
                end else begin
                    hunt = SEEK_FIRST;
                    got  = 0;
                end
            end
            IN_FRAME: begin
                if (got < FRAME_LEN) fbuf[got] = b;
                got++;
                if (got < FRAME_LEN - 1) acc = acc - {8'd0, b};
                if (got >= FRAME_LEN) begin
                    given = {fbuf[FRAME_LEN-1], fbuf[FRAME_LEN-2]};
                    if (typed_on) begin
                        for (int k = 0; k < typed_words; k++) begin
                            pending_words.push_back('{typed_value, 4'(k), k == NUM_WORDS - 1});
                        end
                    end else if (given == acc) begin
                        for (int k = 0; k < NUM_WORDS; k++) begin
                            pending_words.push_back('{{fbuf[3+2*k], fbuf[2+2*k]}, 4'(k),
                                                      k == NUM_WORDS - 1});
                        end
                    end
                    hunt = SEEK_FIRST;
                    got  = 0;
                end
            end
            default: begin
                if (b == cfg_hdr1) begin
                    got = 0;
                    acc = cfg_ck;
                    fbuf[got] = b;
                    got++;
                    acc  = acc - {8'd0, b};
                    hunt = SEEK_SECOND;
                end else begin
                    hunt = SEEK_FIRST;
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        decode_byte(b);
    endtask

    task automatic send_frame(input word_set_t ws, input logic [7:0] sum_flip, input int cut);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] s;
        for (int k = 0; k < FRAME_LEN; k++) fb[k] = 8'($urandom);
        fb[0] = cfg_hdr1;
        fb[1] = cfg_hdr2;
        for (int k = 0; k < NUM_WORDS; k++) begin
            fb[2+2*k] = ws[k][7:0];
            fb[3+2*k] = ws[k][15:8];
        end
        s = cfg_ck;
        for (int k = 0; k < FRAME_LEN - 2; k++) s = s - {8'd0, fb[k]};
        fb[FRAME_LEN-2] = s[7:0] ^ sum_flip;
        fb[FRAME_LEN-1] = s[15:8];
        for (int k = 0; k < cut; k++) send_byte(fb[k]);
    endtask

    // feed bytes until the decoder is back to hunting for a first header
    task automatic to_hunt();
        logic [7:0] b;
        while (hunt != SEEK_FIRST) begin
            b = 8'($urandom);
            if (hunt == SEEK_SECOND && b == cfg_hdr2) b = b ^ 8'h01;
            send_byte(b);
        end
    endtask

    task automatic drain(input int extra);
        rx_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_regs();
        logic [31:0] d;
        apb_read(REG_HEADER_FIRST, d);
        if (d[7:0] !== cfg_hdr1) note_mismatch("header_first readback", 32'(cfg_hdr1), d);
        apb_read(REG_HEADER_SECOND, d);
        if (d[7:0] !== cfg_hdr2) note_mismatch("header_second readback", 32'(cfg_hdr2), d);
        apb_read(REG_CHECKSUM_START, d);
        if (d[15:0] !== cfg_ck) note_mismatch("checksum_start readback", 32'(cfg_ck), d);
    endtask

    task automatic set_config(input logic [7:0] h1, input logic [7:0] h2, input logic [15:0] ck);
        apb_write(REG_HEADER_FIRST, {24'd0, h1});
        apb_write(REG_HEADER_SECOND, {24'd0, h2});
        apb_write(REG_CHECKSUM_START, {16'd0, ck});
        cfg_hdr1 = h1;
        cfg_hdr2 = h2;
        cfg_ck   = ck;
        check_regs();
    endtask

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            chan_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            chan_if.ready <= 1'b0;
        end else begin
            chan_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && chan_if.valid && chan_if.ready) begin
            if (pending_words.size() == 0) begin
                note_mismatch("unexpected channel word", 32'd0, 32'(chan_if.channel_value));
            end else begin
                seen_word = pending_words.pop_front();
                if (chan_if.channel_value !== seen_word.value)
                    note_mismatch("channel_value", 32'(seen_word.value),
                                  32'(chan_if.channel_value));
                if (chan_if.channel_index !== seen_word.index)
                    note_mismatch("channel_index", 32'(seen_word.index),
                                  32'(chan_if.channel_index));
                if (chan_if.last_channel !== seen_word.last)
                    note_mismatch("last_channel", 32'(seen_word.last),
                                  32'(chan_if.last_channel));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stim
        word_set_t   ws;
        logic [7:0]  h;
        int          r;
        int          ph_idle [4]  = '{0, 45, 0, 28};
        int          ph_stall [4] = '{0, 0, 45, 28};

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        chan_if.ready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_req      = 0;
        hold_seen     = 0;
        hold_left     = 0;
        cycles        = 0;
        mismatches    = 0;
        typed_on      = 1'b0;
        cfg_hdr1      = RST_HEADER_FIRST;
        cfg_hdr2      = RST_HEADER_SECOND;
        cfg_ck        = RST_CHECKSUM_START;
        hunt          = SEEK_FIRST;
        got           = 0;
        acc           = RST_CHECKSUM_START;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_regs();

        // directed rows run with no idling on either side
        foreach (dir_rows[i]) begin
            typed_on    = (dir_rows[i].words >= 0);
            typed_words = dir_rows[i].words;
            typed_value = dir_rows[i].fill;
            for (int k = 0; k < NUM_WORDS; k++) ws[k] = dir_rows[i].fill;
            case (dir_rows[i].kind)
                FRAME_OK:      send_frame(ws, 8'h00, FRAME_LEN);
                FRAME_BAD_SUM: send_frame(ws, 8'h01, FRAME_LEN);
                SECOND_HDR_MISS: begin
                    // a failed second header byte equal to the first header
                    // must not restart the frame
                    send_byte(cfg_hdr1);
                    send_byte(cfg_hdr1);
                    send_byte(cfg_hdr2);
                end
                default: begin
                    for (int k = 0; k < NUM_WORDS; k++) ws[k] = 16'($urandom);
                    send_frame(ws, 8'h00, FRAME_LEN);
                end
            endcase
        end
        typed_on = 1'b0;

        for (int p = 1; p < 4; p++) begin
            to_hunt();
            drain(SETTLE);
            idle_pct  = ph_idle[p];
            stall_pct = ph_stall[p];
            case (p)
                1: set_config(8'h00, 8'hFF, 16'h0000);
                2: set_config(8'($urandom), 8'($urandom), 16'($urandom));
                default: begin
                    h = 8'($urandom);
                    set_config(h, h, 16'($urandom));
                end
            endcase

            for (int k = 0; k < NUM_WORDS; k++) ws[k] = 16'($urandom);
            r = (p == 1) ? 0 : $urandom_range(0, 9);
            // receiver held off across a good frame and the byte after it
            if (p == 1) hold_req++;
            if (r <= 5) begin
                send_frame(ws, 8'h00, FRAME_LEN);
            end else if (r == 6) begin
                send_frame(ws, 8'($urandom_range(1, 255)), FRAME_LEN);
            end else if (r == 7) begin
                send_byte(cfg_hdr1);
                h = 8'($urandom);
                if (h == cfg_hdr2) h = h ^ 8'h80;
                send_byte(h);
                send_frame(ws, 8'h00, FRAME_LEN);
            end else if (r == 8) begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
                to_hunt();
                send_frame(ws, 8'h00, FRAME_LEN);
            end else begin
                send_frame(ws, 8'h00, $urandom_range(3, FRAME_LEN - 1));
                to_hunt();
            end
            if (p == 1) send_byte(8'($urandom));
            to_hunt();
            if (p == 2) drain(1);
        end

        to_hunt();
        drain(SETTLE);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
